/* sv/slcd_pkg.sv */
// Package for the sync/length/checksum deframer.
// Holds the queue entry type, operation codes and framing constants.
// No dependencies; imported by the front, queue, back and top files.
package slcd_pkg;

    localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND = 8'h55;
    localparam logic [15:0] HEADER_SPAN = 16'd5;
    localparam logic [7:0]  VERSION_RESET = 8'h01;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Configuration register map (word index taken from paddr[2])
    localparam int          PADDR_W = 3;
    localparam logic        REG_EXPECTED_VERSION = 1'b0;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_END_GOOD = 2'd1,
        KIND_END_BAD  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,   // restart checksum accumulation
        OP_SUM   = 2'd1,   // header byte: accumulate only
        OP_DATA  = 2'd2,   // payload byte: accumulate and emit
        OP_CSUM  = 2'd3    // checksum byte: compare and emit frame end
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  data;
        logic [15:0] index;
        logic [15:0] length;
        logic [7:0]  seq;
        logic [7:0]  module_id;
        logic [7:0]  command;
    } entry_t;

endpackage

/* sv/slcd_intf.sv */
// Stream interfaces for the deframer: received-byte channel and result channel.
// Depends on nothing; used by slcd_front, slcd_back and the top level.
interface slcd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slcd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  item_kind;
    logic [7:0]  data_byte;
    logic [15:0] payload_index;
    logic [15:0] payload_length;
    logic [7:0]  seq_number;
    logic [7:0]  module_id;
    logic [7:0]  command_code;

    modport source (output valid, output item_kind, output data_byte,
                    output payload_index, output payload_length,
                    output seq_number, output module_id, output command_code,
                    input ready);
    modport sink   (input valid, input item_kind, input data_byte,
                    input payload_index, input payload_length,
                    input seq_number, input module_id, input command_code,
                    output ready);
endinterface

/* sv/slcd_front.sv */
// Front end of the deframer: frame parser that classifies each received beat.
// Depends on slcd_pkg and slcd_byte_if; pushes operations into slcd_queue.
module slcd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    slcd_byte_if.sink            rx,
    input  logic [7:0]           expected_version,
    output logic                 push,
    output slcd_pkg::entry_t     push_entry,
    input  logic                 push_ready
);
    import slcd_pkg::*;

    typedef enum logic [3:0] {
        PH_HUNT, PH_SYNC2, PH_LEN_LO, PH_LEN_HI, PH_VER,
        PH_SEQ, PH_MOD, PH_CMD, PH_DATA, PH_CSUM
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [15:0] counter_reg, counter_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  mod_reg, mod_next;
    logic [7:0]  cmd_reg, cmd_next;

    logic        accept;
    logic        emit;
    op_t         op;
    logic [7:0]  b;
    logic [15:0] len_field;
    logic [15:0] total_len;

    assign rx.ready  = push_ready;
    assign accept    = rx.valid && push_ready;
    assign b         = rx.rx_byte;
    assign len_field = {b, remaining_reg[7:0]};
    assign total_len = counter_reg + remaining_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        counter_next   = counter_reg;
        seq_next       = seq_reg;
        mod_next       = mod_reg;
        cmd_next       = cmd_reg;
        emit           = 1'b0;
        op             = OP_SUM;
        case (phase_reg)
            PH_HUNT:
            begin
                if (b == SYNC_FIRST)
                    phase_next = PH_SYNC2;
            end
            PH_SYNC2:  phase_next = (b == SYNC_SECOND) ? PH_LEN_LO : PH_HUNT;
            PH_LEN_LO:
            begin
                remaining_next = {8'd0, b};
                phase_next     = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                emit = 1'b1;
                op   = OP_CLEAR;
                if (len_field < HEADER_SPAN)
                    phase_next = PH_HUNT;
                else
                begin
                    remaining_next = len_field - HEADER_SPAN;
                    counter_next   = 16'd0;
                    phase_next     = PH_VER;
                end
            end
            PH_VER:
            begin
                if (b != expected_version)
                    phase_next = PH_HUNT;
                else
                begin
                    emit       = 1'b1;
                    phase_next = PH_SEQ;
                end
            end
            PH_SEQ:
            begin
                emit       = 1'b1;
                seq_next   = b;
                phase_next = PH_MOD;
            end
            PH_MOD:
            begin
                emit       = 1'b1;
                mod_next   = b;
                phase_next = PH_CMD;
            end
            PH_CMD:
            begin
                emit       = 1'b1;
                cmd_next   = b;
                phase_next = (remaining_reg == 16'd0) ? PH_CSUM : PH_DATA;
            end
            PH_DATA:
            begin
                emit           = 1'b1;
                op             = OP_DATA;
                counter_next   = counter_reg + 16'd1;
                remaining_next = remaining_reg - 16'd1;
                if (remaining_reg == 16'd1)
                    phase_next = PH_CSUM;
            end
            PH_CSUM:
            begin
                emit       = 1'b1;
                op         = OP_CSUM;
                phase_next = PH_HUNT;
            end
            default:   phase_next = PH_HUNT;
        endcase
    end

    // Header fields travel with every entry; the back end latches what it emits.
    // The checksum byte rides in the data field for the compare.
    always_comb
    begin
        push_entry.op        = op;
        push_entry.data      = b;
        push_entry.index     = (op == OP_CSUM) ? 16'd0 : counter_reg;
        push_entry.length    = (op == OP_CSUM) ? counter_reg : total_len;
        push_entry.seq       = seq_next;
        push_entry.module_id = mod_next;
        push_entry.command   = cmd_next;
    end

    assign push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            remaining_reg <= 16'd0;
            counter_reg   <= 16'd0;
            seq_reg       <= 8'd0;
            mod_reg       <= 8'd0;
            cmd_reg       <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            counter_reg   <= counter_next;
            seq_reg       <= seq_next;
            mod_reg       <= mod_next;
            cmd_reg       <= cmd_next;
        end
    end

endmodule

/* sv/slcd_queue.sv */
// Short operation queue between the parser front end and the checksum back end.
// Depends on slcd_pkg for the entry type and depth.
module slcd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  slcd_pkg::entry_t     push_entry,
    output logic                 push_ready,
    output logic                 pop_valid,
    output slcd_pkg::entry_t     pop_entry,
    input  logic                 pop
);
    import slcd_pkg::*;

    entry_t              slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != QUEUE_DEPTH[QUEUE_AW:0]);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

/* sv/slcd_back.sv */
// Back end of the deframer: running checksum and result output register.
// Depends on slcd_pkg and slcd_result_if; pops operations from slcd_queue.
module slcd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    input  slcd_pkg::entry_t     pop_entry,
    output logic                 pop,
    slcd_result_if.source        res
);
    import slcd_pkg::*;

    logic [7:0]  sum_reg, sum_next;
    logic        out_valid_reg, out_valid_next;
    kind_t       kind_reg;
    logic [7:0]  data_reg;
    logic [15:0] index_reg, length_reg;
    logic [7:0]  seq_reg, mod_reg, cmd_reg;
    logic        out_free;
    logic        load;

    assign out_free = !out_valid_reg || res.ready;
    assign pop      = pop_valid && out_free;
    assign load     = pop && (pop_entry.op == OP_DATA || pop_entry.op == OP_CSUM);

    always_comb
    begin
        sum_next = sum_reg;
        if (pop)
        begin
            case (pop_entry.op)
                OP_CLEAR: sum_next = 8'd0;
                OP_SUM:   sum_next = sum_reg + pop_entry.data;
                OP_DATA:  sum_next = sum_reg + pop_entry.data;
                OP_CSUM:  sum_next = sum_reg;
                default:  sum_next = sum_reg;
            endcase
        end
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on a result-producing operation, hold otherwise
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pop_entry.op == OP_CSUM)
                kind_reg <= (pop_entry.data == sum_reg) ? KIND_END_GOOD : KIND_END_BAD;
            else
                kind_reg <= KIND_PAYLOAD;
            data_reg   <= (pop_entry.op == OP_CSUM) ? 8'd0 : pop_entry.data;
            index_reg  <= pop_entry.index;
            length_reg <= pop_entry.length;
            seq_reg    <= pop_entry.seq;
            mod_reg    <= pop_entry.module_id;
            cmd_reg    <= pop_entry.command;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.item_kind      = kind_reg;
    assign res.data_byte      = data_reg;
    assign res.payload_index  = index_reg;
    assign res.payload_length = length_reg;
    assign res.seq_number     = seq_reg;
    assign res.module_id      = mod_reg;
    assign res.command_code   = cmd_reg;

    a_hold_under_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res.ready |=> out_valid_reg)
        else $error("result dropped while stalled");

    a_no_pop_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res.ready |-> !pop)
        else $error("queue popped into a blocked output register");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (kind_reg == KIND_PAYLOAD || kind_reg == KIND_END_GOOD ||
                           kind_reg == KIND_END_BAD))
        else $error("illegal result kind");

endmodule

/* sv/sync_length_checksum_deframer_top.sv */
// Top level of the sync/length/checksum deframer with APB configuration port.
// Depends on slcd_pkg, slcd_intf, slcd_front, slcd_queue and slcd_back.
//
//  channel   direction  beat contents
//  rx        in         rx_byte
//  res       out        item_kind, data_byte, payload_index, payload_length,
//                       seq_number, module_id, command_code
//  apb       in/out     expected_version at byte address 0
//
// One received byte is taken per cycle while the queue has room; the front parser
// decides its class in the cycle it is taken, and the entry passes through the
// queue before the back end registers any result. A four-entry queue parts the
// parser from the checksum/output stage, so the rx side keeps moving until the
// queue fills behind a stalled res consumer. Reset returns the parser to hunting
// for the first sync byte, clears the checksum and sets expected_version to 1.
module sync_length_checksum_deframer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    slcd_byte_if.sink                     rx,
    slcd_result_if.source                 res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [slcd_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import slcd_pkg::*;

    logic [7:0] version_reg;
    logic       push, push_ready, pop_valid, pop;
    entry_t     push_entry, pop_entry;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_EXPECTED_VERSION) ? {24'd0, version_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            version_reg <= VERSION_RESET;
        else if (cfg_write && paddr[2] == REG_EXPECTED_VERSION)
            version_reg <= pwdata[7:0];
    end

    slcd_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .rx               (rx),
        .expected_version (version_reg),
        .push             (push),
        .push_entry       (push_entry),
        .push_ready       (push_ready)
    );

    slcd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop        (pop)
    );

    slcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_entry (pop_entry),
        .pop       (pop),
        .res       (res)
    );

endmodule
